// ----- design/stk_pkg.sv -----
// Package for the STK500v1 command handler: protocol codes, phases, action codes.
// No dependencies.
`timescale 1ns / 1ps
package stk_pkg;
  localparam int BUFFER_BYTES = 256;
  localparam int BUF_AW = $clog2(BUFFER_BYTES);
  localparam int ERASE_PAGE_BYTES = 512;
  localparam logic [15:0] ERASE_MASK = 16'(ERASE_PAGE_BYTES - 1);

  localparam logic [7:0] C_EOP = 8'h20;
  localparam logic [7:0] C_INSYNC = 8'h14;
  localparam logic [7:0] C_NOSYNC = 8'h15;
  localparam logic [7:0] C_OK = 8'h10;
  localparam logic [7:0] C_UNKNOWN = 8'h03;
  localparam logic [7:0] C_ZERO = 8'h00;
  localparam logic [7:0] CMD_PARAM = 8'h41;
  localparam logic [7:0] CMD_SETDEV = 8'h42;
  localparam logic [7:0] CMD_SETDEVX = 8'h45;
  localparam logic [7:0] CMD_LOADADDR = 8'h55;
  localparam logic [7:0] CMD_UNIV = 8'h56;
  localparam logic [7:0] CMD_PROG = 8'h64;
  localparam logic [7:0] CMD_READ = 8'h74;
  localparam logic [7:0] CMD_SIGN = 8'h75;
  localparam logic [7:0] PARM_HW = 8'h80;
  localparam logic [7:0] PARM_SWMAJ = 8'h81;
  localparam logic [7:0] PARM_SWMIN = 8'h82;
  localparam logic [15:0] BASE_ADDR = 16'h1000;
  localparam logic [15:0] AREA_END = 16'h2000;
  localparam logic [15:0] SETDEV_LEN = 16'd20;
  localparam logic [15:0] SETDEVX_LEN = 16'd5;
  localparam logic [15:0] UNIV_LEN = 16'd4;

  localparam logic [1:0] KIND_SERIAL = 2'd0;
  localparam logic [1:0] KIND_FDATA = 2'd1;
  localparam logic [1:0] KIND_FDONE = 2'd2;

  localparam logic [1:0] ACT_TX = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [1:0] REG_SWMAJ = 2'd0;
  localparam logic [1:0] REG_SWMIN = 2'd1;
  localparam logic [1:0] REG_HW = 2'd2;
  localparam logic [1:0] REG_SIG = 2'd3;

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_EOP     = 14'b00000000000010,
    PH_SKIP    = 14'b00000000000100,
    PH_SEL     = 14'b00000000001000,
    PH_ALO     = 14'b00000000010000,
    PH_AHI     = 14'b00000000100000,
    PH_LHI     = 14'b00000001000000,
    PH_LLO     = 14'b00000010000000,
    PH_MEM     = 14'b00000100000000,
    PH_DATA    = 14'b00001000000000,
    PH_ERASE   = 14'b00010000000000,
    PH_WRITE   = 14'b00100000000000,
    PH_RDWAIT  = 14'b01000000000000,
    PH_SIGTAIL = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
  } act_t;

  // Results of one input item, up to three, plus count.
  typedef struct packed {
    logic [1:0] count;
    act_t       r0;
    act_t       r1;
    act_t       r2;
  } res_t;
endpackage

// ----- design/stk500v1_command_handler_core.sv -----
// Top level of the STK500v1 command handler: input register, engine, output queue, config.
// Depends on stk_pkg, stk_engine, stk_outq.
`timescale 1ns / 1ps
// Bootloader-side STK500v1 command engine. Input transactions carry received serial
// bytes, flash read data and flash completion events; output transactions carry
// transmit bytes and flash erase, write and read requests, with last set on the final
// action caused by an input. An input item can be taken in every cycle as long as the
// eight-entry output queue, counting the actions of the item in the input register,
// still has room for three more, and is held back whenever it lacks that room. Results
// pass through the input register, then the queue. Registers are written through the
// cfg port, by the user only while the block is idle; the block does not enforce this.
module stk500v1_command_handler_core
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [1:0] action, [17:2] flash_address,
                                     // [25:18] out_byte, [26] last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic        in_valid;
  logic [1:0]  in_kind;
  logic [7:0]  in_byte;
  logic [7:0]  ver_major, ver_minor, hw_version;
  logic [23:0] signature;
  logic        has_room;
  res_t        res;

  // Queue room already accounts for the actions of the item in the input register.
  assign s_axis_tready = has_room;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else in_valid <= s_axis_tvalid && s_axis_tready;
    in_kind <= s_axis_tuser;
    in_byte <= s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ver_major <= 8'd4;
      ver_minor <= 8'd4;
      hw_version <= 8'd3;
      signature <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWMAJ: ver_major <= cfg_data[7:0];
        REG_SWMIN: ver_minor <= cfg_data[7:0];
        REG_HW:    hw_version <= cfg_data[7:0];
        REG_SIG:   signature <= cfg_data;
        default:   ;
      endcase
    end
  end

  stk_engine u_engine (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_kind(in_kind), .in_byte(in_byte),
    .ver_major(ver_major), .ver_minor(ver_minor), .hw_version(hw_version),
    .signature(signature), .res(res)
  );

  stk_outq u_outq (
    .clk(clk), .rst(rst), .res(res), .has_room(has_room),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );
endmodule

// ----- design/stk_engine.sv -----
// Protocol engine: decodes one registered input item per cycle into up to three actions.
// Depends on stk_pkg.
`timescale 1ns / 1ps
module stk_engine
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  ver_major,
  input  logic [7:0]  ver_minor,
  input  logic [7:0]  hw_version,
  input  logic [23:0] signature,
  output res_t        res
);
  phase_t      phase, phase_next;
  logic [7:0]  command, command_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  selector, selector_next;
  logic [15:0] length, length_next;
  logic [15:0] index, index_next;
  logic [15:0] address, address_next;
  logic [7:0]  page_store [BUFFER_BYTES];
  logic        store_we;
  logic [7:0]  store_rd;
  logic [BUF_AW-1:0] rd_addr;
  logic [15:0] stored;
  logic        serial;
  logic [15:0] word;
  logic [15:0] idx_inc;
  logic [15:0] addr_inc;
  logic [7:0]  pvalue;

  assign serial = (in_kind == KIND_SERIAL);
  assign stored = (length < 16'(BUFFER_BYTES)) ? length : 16'(BUFFER_BYTES);
  assign idx_inc = index + 16'd1;
  assign addr_inc = address + 16'd1;
  assign word = {in_byte, selector} << 1;
  // Prefetch the byte the next write needs: entry 0 while waiting for the end byte,
  // else the next index. A same-cycle store to that entry is bypassed.
  assign rd_addr = (phase_next == PH_EOP) ? '0 : index_next[BUF_AW-1:0];
  assign store_we = in_valid && (phase == PH_DATA) && serial
                    && (index < 16'(BUFFER_BYTES));

  always_ff @(posedge clk) begin
    if (store_we) page_store[index[BUF_AW-1:0]] <= in_byte;
    if (store_we && (index[BUF_AW-1:0] == rd_addr)) store_rd <= in_byte;
    else store_rd <= page_store[rd_addr];
  end

  always_comb begin
    case (selector)
      PARM_SWMIN: pvalue = ver_minor;
      PARM_SWMAJ: pvalue = ver_major;
      PARM_HW:    pvalue = hw_version;
      default:    pvalue = C_UNKNOWN;
    endcase
  end

  function automatic act_t txa(input logic [7:0] b);
    txa = '{action: ACT_TX, addr: 16'd0, data: b};
  endfunction

  always_comb begin
    phase_next = phase;
    command_next = command;
    remaining_next = remaining;
    selector_next = selector;
    length_next = length;
    index_next = index;
    address_next = address;
    res = '0;
    if (in_valid) begin
      case (phase)
        PH_IDLE, PH_SIGTAIL: begin
          if (phase == PH_SIGTAIL) begin
            res.count = 2'd2;
            res.r0 = txa(signature[7:0]);
            res.r1 = txa(C_OK);
            phase_next = PH_IDLE;
          end
          if (serial) begin
            command_next = in_byte;
            case (in_byte)
              CMD_PARAM: phase_next = PH_SEL;
              CMD_SETDEV: begin
                remaining_next = SETDEV_LEN;
                phase_next = PH_SKIP;
              end
              CMD_SETDEVX: begin
                remaining_next = SETDEVX_LEN;
                phase_next = PH_SKIP;
              end
              CMD_UNIV: begin
                remaining_next = UNIV_LEN;
                phase_next = PH_SKIP;
              end
              CMD_LOADADDR: phase_next = PH_ALO;
              CMD_PROG, CMD_READ: phase_next = PH_LHI;
              default: phase_next = PH_EOP;
            endcase
          end
        end
        PH_EOP: if (serial) begin
          phase_next = PH_IDLE;
          if (in_byte != C_EOP) begin
            res.count = 2'd1;
            res.r0 = txa(C_NOSYNC);
          end else begin
            res.r0 = txa(C_INSYNC);
            case (command)
              CMD_PARAM: begin
                res.count = 2'd3;
                res.r1 = txa(pvalue);
                res.r2 = txa(C_OK);
              end
              CMD_UNIV: begin
                res.count = 2'd3;
                res.r1 = txa(C_ZERO);
                res.r2 = txa(C_OK);
              end
              CMD_PROG: begin
                res.count = 2'd2;
                if (address >= BASE_ADDR && address < AREA_END) begin
                  index_next = 16'd0;
                  res.r1 = '{action: ACT_ERASE, addr: address & ~ERASE_MASK, data: 8'd0};
                  phase_next = PH_ERASE;
                end else if (stored != 16'd0) begin
                  res.r1 = '{action: ACT_WRITE, addr: address, data: store_rd};
                  address_next = addr_inc;
                  index_next = 16'd1;
                  phase_next = PH_WRITE;
                end else begin
                  index_next = 16'd0;
                  address_next = address + length;
                  res.r1 = txa(C_OK);
                end
              end
              CMD_READ: begin
                res.count = 2'd2;
                index_next = 16'd0;
                if (length == 16'd0) res.r1 = txa(C_OK);
                else begin
                  res.r1 = '{action: ACT_READ, addr: address, data: 8'd0};
                  phase_next = PH_RDWAIT;
                end
              end
              CMD_SIGN: begin
                res.count = 2'd3;
                res.r1 = txa(signature[23:16]);
                res.r2 = txa(signature[15:8]);
                phase_next = PH_SIGTAIL;
              end
              default: begin
                res.count = 2'd2;
                res.r1 = txa(C_OK);
              end
            endcase
          end
        end
        PH_SKIP: if (serial) begin
          remaining_next = remaining - 16'd1;
          if (remaining_next == 16'd0) phase_next = PH_EOP;
        end
        PH_SEL: if (serial) begin
          selector_next = in_byte;
          phase_next = PH_EOP;
        end
        PH_ALO: if (serial) begin
          selector_next = in_byte;
          phase_next = PH_AHI;
        end
        PH_AHI: if (serial) begin
          address_next = BASE_ADDR + word;
          phase_next = PH_EOP;
        end
        PH_LHI: if (serial) begin
          length_next = {in_byte, 8'd0};
          phase_next = PH_LLO;
        end
        PH_LLO: if (serial) begin
          length_next = length | {8'd0, in_byte};
          phase_next = PH_MEM;
        end
        PH_MEM: if (serial) begin
          index_next = 16'd0;
          if (command == CMD_PROG && length != 16'd0) phase_next = PH_DATA;
          else phase_next = PH_EOP;
        end
        PH_DATA: if (serial) begin
          index_next = idx_inc;
          if (idx_inc == length) phase_next = PH_EOP;
        end
        PH_ERASE, PH_WRITE: if (in_kind == KIND_FDONE) begin
          res.count = 2'd1;
          if (index < stored) begin
            res.r0 = '{action: ACT_WRITE, addr: address, data: store_rd};
            address_next = addr_inc;
            index_next = idx_inc;
            phase_next = PH_WRITE;
          end else begin
            address_next = address + (length - stored);
            res.r0 = txa(C_OK);
            phase_next = PH_IDLE;
          end
        end
        PH_RDWAIT: if (in_kind == KIND_FDATA) begin
          res.count = 2'd2;
          res.r0 = txa(in_byte);
          address_next = addr_inc;
          index_next = idx_inc;
          if (idx_inc < length) begin
            res.r1 = '{action: ACT_READ, addr: addr_inc, data: 8'd0};
          end else begin
            res.r1 = txa(C_OK);
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      command <= 8'd0;
      remaining <= 16'd0;
      selector <= 8'd0;
      length <= 16'd0;
      index <= 16'd0;
      address <= BASE_ADDR;
    end else begin
      phase <= phase_next;
      command <= command_next;
      remaining <= remaining_next;
      selector <= selector_next;
      length <= length_next;
      index <= index_next;
      address <= address_next;
    end
  end
endmodule

// ----- design/stk_outq.sv -----
// Output queue: holds the result actions of items and serves them one per transaction.
// Depends on stk_pkg.
`timescale 1ns / 1ps
module stk_outq
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  res_t        res,
  output logic        has_room,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);
  localparam int DEPTH = 8;
  localparam int AW = 3;
  act_t          q [DEPTH];
  logic          qlast [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   fill, fill_next;
  logic          pop;
  logic [AW-1:0] w1, w2;

  assign pop = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (fill != '0);
  // Fields from bit 0: action, flash_address, out_byte, last, zero pad.
  assign m_axis_tdata = {5'd0, qlast[rp], q[rp].data, q[rp].addr, q[rp].action};
  // Room for a full item of three results beside those arriving this cycle,
  // counted without the pop of this cycle.
  assign has_room = (({1'b0, fill} + (AW+2)'(res.count)) <= (AW+2)'(DEPTH - 3));
  assign w1 = wp + AW'(1);
  assign w2 = wp + AW'(2);
  assign fill_next = fill + (AW+1)'(res.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      q[wp] <= res.r0;
      qlast[wp] <= (res.count == 2'd1);
    end
    if (res.count >= 2'd2) begin
      q[w1] <= res.r1;
      qlast[w1] <= (res.count == 2'd2);
    end
    if (res.count == 2'd3) begin
      q[w2] <= res.r2;
      qlast[w2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      wp <= wp + AW'(res.count);
      rp <= rp + AW'(pop);
      fill <= fill_next;
    end
  end
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for stk500v1_command_handler_core: drives STK500v1 packets
// and flash events, predicts every action in a local model and checks the output stream.
// Depends on stk_pkg and the design sources.
`timescale 1ns / 1ps
module testbench;
  import stk_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [1:0] action, [17:2] flash_address,
                                       // [25:18] out_byte, [26] last
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [23:0] cfg_data = 24'h0;

  stk500v1_command_handler_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Handler model state
  phase_t      ph = PH_IDLE;
  logic [7:0]  cmd = 8'h00, sel = 8'h00;
  logic [15:0] remaining = 16'h0, xlen = 16'h0, xidx = 16'h0, addr = BASE_ADDR;
  logic [7:0]  page_buf [BUFFER_BYTES];
  logic [7:0]  ver_major = 8'd4, ver_minor = 8'd4, hw_ver = 8'd3;
  logic [23:0] signature = 24'h0;

  logic [26:0] step_actions[$];
  logic [26:0] expected_actions[$];
  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  int ready_stall = 0;

  function automatic void emit(logic [1:0] a, logic [15:0] ad, logic [7:0] d);
    step_actions.push_back({1'b0, d, ad, a});
  endfunction

  function automatic logic [15:0] stored_cnt();
    return (xlen < BUFFER_BYTES) ? xlen : 16'(BUFFER_BYTES);
  endfunction

  function automatic void next_write();
    if (xidx < stored_cnt()) begin
      emit(ACT_WRITE, addr, page_buf[xidx[BUF_AW-1:0]]);
      addr = addr + 16'd1;
      xidx = xidx + 16'd1;
      ph = PH_WRITE;
    end else begin
      addr = addr + (xlen - stored_cnt());
      emit(ACT_TX, 16'h0, C_OK);
      ph = PH_IDLE;
    end
  endfunction

  function automatic void command_byte(logic [7:0] b);
    cmd = b;
    case (b)
      CMD_PARAM: ph = PH_SEL;
      CMD_SETDEV: begin remaining = SETDEV_LEN; ph = PH_SKIP; end
      CMD_SETDEVX: begin remaining = SETDEVX_LEN; ph = PH_SKIP; end
      CMD_UNIV: begin remaining = UNIV_LEN; ph = PH_SKIP; end
      CMD_LOADADDR: ph = PH_ALO;
      CMD_PROG, CMD_READ: ph = PH_LHI;
      default: ph = PH_EOP;
    endcase
  endfunction

  function automatic void end_byte(logic [7:0] b);
    logic [7:0] v;
    ph = PH_IDLE;
    if (b != C_EOP) begin
      emit(ACT_TX, 16'h0, C_NOSYNC);
      return;
    end
    emit(ACT_TX, 16'h0, C_INSYNC);
    case (cmd)
      CMD_PARAM: begin
        if (sel == PARM_SWMIN) v = ver_minor;
        else if (sel == PARM_SWMAJ) v = ver_major;
        else if (sel == PARM_HW) v = hw_ver;
        else v = C_UNKNOWN;
        emit(ACT_TX, 16'h0, v);
        emit(ACT_TX, 16'h0, C_OK);
      end
      CMD_UNIV: begin
        emit(ACT_TX, 16'h0, C_ZERO);
        emit(ACT_TX, 16'h0, C_OK);
      end
      CMD_PROG: begin
        xidx = 16'h0;
        if (addr >= BASE_ADDR && addr < AREA_END) begin
          emit(ACT_ERASE, addr & ~ERASE_MASK, 8'h00);
          ph = PH_ERASE;
        end else begin
          next_write();
        end
      end
      CMD_READ: begin
        xidx = 16'h0;
        if (xlen == 16'h0) begin
          emit(ACT_TX, 16'h0, C_OK);
        end else begin
          emit(ACT_READ, addr, 8'h00);
          ph = PH_RDWAIT;
        end
      end
      CMD_SIGN: begin
        emit(ACT_TX, 16'h0, signature[23:16]);
        emit(ACT_TX, 16'h0, signature[15:8]);
        ph = PH_SIGTAIL;
      end
      default: emit(ACT_TX, 16'h0, C_OK);
    endcase
  endfunction

  // Predict the actions caused by one accepted input transaction.
  function automatic void predict_actions(logic [1:0] k, logic [7:0] b);
    logic ser;
    logic [15:0] w;
    logic [26:0] tail;
    ser = (k == KIND_SERIAL);
    step_actions.delete();
    case (ph)
      PH_IDLE: if (ser) command_byte(b);
      PH_EOP: if (ser) end_byte(b);
      PH_SKIP: if (ser) begin
        remaining = remaining - 16'd1;
        if (remaining == 16'h0) ph = PH_EOP;
      end
      PH_SEL: if (ser) begin sel = b; ph = PH_EOP; end
      PH_ALO: if (ser) begin sel = b; ph = PH_AHI; end
      PH_AHI: if (ser) begin
        w = {b, sel};
        addr = BASE_ADDR + (w << 1);
        ph = PH_EOP;
      end
      PH_LHI: if (ser) begin xlen = {b, 8'h00}; ph = PH_LLO; end
      PH_LLO: if (ser) begin xlen = xlen | {8'h00, b}; ph = PH_MEM; end
      PH_MEM: if (ser) begin
        xidx = 16'h0;
        ph = (cmd == CMD_PROG && xlen != 16'h0) ? PH_DATA : PH_EOP;
      end
      PH_DATA: if (ser) begin
        if (xidx < BUFFER_BYTES) page_buf[xidx[BUF_AW-1:0]] = b;
        xidx = xidx + 16'd1;
        if (xidx == xlen) ph = PH_EOP;
      end
      PH_ERASE, PH_WRITE: if (k == KIND_FDONE) next_write();
      PH_RDWAIT: if (k == KIND_FDATA) begin
        emit(ACT_TX, 16'h0, b);
        addr = addr + 16'd1;
        xidx = xidx + 16'd1;
        if (xidx < xlen) begin
          emit(ACT_READ, addr, 8'h00);
        end else begin
          emit(ACT_TX, 16'h0, C_OK);
          ph = PH_IDLE;
        end
      end
      PH_SIGTAIL: begin
        emit(ACT_TX, 16'h0, signature[7:0]);
        emit(ACT_TX, 16'h0, C_OK);
        ph = PH_IDLE;
        if (ser) command_byte(b);
      end
      default: ph = PH_IDLE;
    endcase
    if (step_actions.size() > 0) begin
      tail = step_actions[step_actions.size()-1];
      tail[26] = 1'b1;
      step_actions[step_actions.size()-1] = tail;
    end
    foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
  endfunction

  // Sends one input transaction; tvalid stays high unless a gap follows.
  // Ready is sampled mid-cycle, where it holds the value seen by the next edge.
  task automatic send(logic [1:0] k, logic [7:0] b);
    logic acc;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= b;
    do begin
      @(negedge clk);
      acc = s_axis_tready;
      @(posedge clk);
    end while (!acc);
    predict_actions(k, b);
    items_sent++;
  endtask

  // Answer pending flash operations, with an occasional event of random kind mixed in.
  task automatic serve_flash();
    while (ph == PH_ERASE || ph == PH_WRITE || ph == PH_RDWAIT) begin
      if ($urandom_range(0, 7) == 0)
        send(2'($urandom_range(0, 3)), 8'($urandom));
      else
        send((ph == PH_RDWAIT) ? KIND_FDATA : KIND_FDONE, 8'($urandom));
    end
  endtask

  // One command packet; arg is the selector, word address or length.
  task automatic packet(logic [7:0] c, logic [15:0] arg, logic [7:0] eop);
    send(KIND_SERIAL, c);
    while (ph != PH_EOP && ph != PH_IDLE) begin
      case (ph)
        PH_SEL, PH_ALO, PH_LLO: send(KIND_SERIAL, arg[7:0]);
        PH_AHI, PH_LHI: send(KIND_SERIAL, arg[15:8]);
        default: send(KIND_SERIAL, 8'($urandom));
      endcase
    end
    if (ph == PH_EOP) send(KIND_SERIAL, eop);
    serve_flash();
  endtask

  task automatic drain();
    if (ph == PH_SIGTAIL) send(KIND_FDONE, 8'($urandom));
    s_axis_tvalid <= 1'b0;
    while (expected_actions.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] maj, logic [7:0] mnr, logic [7:0] hw, logic [23:0] sig);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_SWMAJ; cfg_data <= {16'h0, maj};
    @(posedge clk);
    cfg_index <= REG_SWMIN; cfg_data <= {16'h0, mnr};
    @(posedge clk);
    cfg_index <= REG_HW; cfg_data <= {16'h0, hw};
    @(posedge clk);
    cfg_index <= REG_SIG; cfg_data <= sig;
    @(posedge clk);
    cfg_we <= 1'b0;
    ver_major = maj; ver_minor = mnr; hw_ver = hw; signature = sig;
  endtask

  function automatic logic [7:0] unknown_cmd();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c inside {CMD_PARAM, CMD_SETDEV, CMD_SETDEVX, CMD_LOADADDR, CMD_UNIV,
                     CMD_PROG, CMD_READ, CMD_SIGN});
    return c;
  endfunction

  function automatic logic [7:0] some_eop();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : C_EOP;
  endfunction

  task automatic test_basic_commands();
    packet(8'h30, 16'h0, C_EOP);
    packet(8'h30, 16'h0, 8'hDF);             // bad end byte
    packet(CMD_PARAM, {8'h0, PARM_HW}, C_EOP);
    packet(CMD_PARAM, 16'h00FF, C_EOP);      // unknown parameter
    packet(CMD_UNIV, 16'h0, C_EOP);
    packet(CMD_SETDEVX, 16'h0, 8'h00);
    send(2'd3, 8'hFF);                       // kind outside the set
  endtask

  task automatic test_flash_paths();
    packet(CMD_LOADADDR, 16'h0123, C_EOP);   // in range, unaligned erase
    packet(CMD_PROG, 16'd3, C_EOP);
    packet(CMD_READ, 16'd2, C_EOP);
    packet(CMD_READ, 16'd0, C_EOP);
    packet(CMD_PROG, 16'd0, C_EOP);          // zero length still erases
    packet(CMD_LOADADDR, 16'h77FF, 8'h21);   // bad end, address still loaded
    packet(CMD_PROG, 16'd4, C_EOP);          // wraps past 0xFFFF
  endtask

  task automatic test_signature();
    set_regs(8'h00, 8'h00, 8'h00, 24'h000000);
    packet(CMD_SIGN, 16'h0, C_EOP);
    packet(CMD_PARAM, {8'h0, PARM_SWMAJ}, C_EOP);  // taken through the signature tail
    set_regs(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
    packet(CMD_SIGN, 16'h0, C_EOP);
    send(KIND_FDATA, 8'hA5);
    packet(CMD_PARAM, {8'h0, PARM_SWMIN}, C_EOP);
    packet(CMD_SIGN, 16'h0, 8'h00);
  endtask

  task automatic test_random();
    int stop_at;
    int tail_at;
    logic [7:0] pick;
    stop_at = items_sent + 24;
    tail_at = items_sent + 14;
    while (items_sent < stop_at) begin
      if (items_sent >= tail_at) idle_en = 1'b0;
      if ($urandom_range(0, 19) == 0)
        set_regs(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
      case ($urandom_range(0, 10))
        0: begin
          pick = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h80, 8'h82));
          packet(CMD_PARAM, {8'h0, pick}, some_eop());
        end
        1: packet(CMD_UNIV, 16'h0, some_eop());
        2: packet(CMD_SETDEV, 16'h0, some_eop());
        3: packet(CMD_SETDEVX, 16'h0, some_eop());
        4: packet(CMD_LOADADDR, 16'($urandom), some_eop());
        5: packet(CMD_PROG, 16'($urandom_range(0, 8)), some_eop());
        6: packet(CMD_READ, 16'($urandom_range(0, 6)), some_eop());
        7: packet(CMD_SIGN, 16'h0, some_eop());
        8: packet(unknown_cmd(), 16'h0, some_eop());
        9: send(2'($urandom_range(1, 3)), 8'($urandom));
        default: begin
          packet(CMD_LOADADDR, 16'($urandom_range(0, 16'h07FF)), C_EOP);
          packet(CMD_PROG, 16'($urandom_range(1, 8)), some_eop());
        end
      endcase
    end
  endtask

  // Output side: random ready stalls while idling is enabled.
  always @(posedge clk) begin
    if (!idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_stall <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [26:0] exp_a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected action, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_a = expected_actions.pop_front();
        if (m_axis_tdata[1:0] !== exp_a[1:0]) begin
          $display("%0t: action expected %0d actual %0d", $time, exp_a[1:0],
                   m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[17:2] !== exp_a[17:2]) begin
          $display("%0t: flash_address expected %h actual %h", $time, exp_a[17:2],
                   m_axis_tdata[17:2]);
          errors++;
        end
        if (m_axis_tdata[25:18] !== exp_a[25:18]) begin
          $display("%0t: out_byte expected %h actual %h", $time, exp_a[25:18],
                   m_axis_tdata[25:18]);
          errors++;
        end
        if (m_axis_tdata[26] !== exp_a[26]) begin
          $display("%0t: last expected %b actual %b", $time, exp_a[26], m_axis_tdata[26]);
          errors++;
        end
        if (m_axis_tdata[31:27] !== 5'h0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[31:27]);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_commands();
    test_flash_paths();
    test_signature();
    set_regs(8'd4, 8'd4, 8'd3, 24'h1E950F);
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
